### design/hdls_pkg.sv
// Shared types and constants for the hazard DAG level scheduler.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none

package hdls_pkg;

  // Command codes carried in the input tuser field.
  localparam logic [1:0] MODE_ADD   = 2'd0;
  localparam logic [1:0] MODE_SCHED = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  // Result status codes carried in the output tuser field.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DUP   = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_CYCLE = 2'd3;

  // Fixed field widths of the stream payloads.
  localparam int MASK_W     = 32;
  localparam int NODE_W     = 5;
  localparam int LEVEL_W    = 5;
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 16;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;     // latch an add item and restart the row walk
    logic sch_init;    // load remaining and done sets for a schedule
    logic add_step;    // process one earlier row for the node being added
    logic add_commit;  // write the new row and present the add result
    logic full_rsp;    // present the table-full result
    logic clr;         // empty the table and present the clear result
    logic eval_step;   // test one row for readiness in this round
    logic emit;        // present the lowest ready node
    logic cyc_emit;    // present the cycle result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;        // output register can take a result this cycle
    logic count_zero;      // table holds no node
    logic table_full;      // table holds the maximum number of nodes
    logic scan_done;       // row walk is at the last valid row
    logic remaining_zero;  // no running node left to release
    logic ready_zero;      // this round released nothing
    logic ready_one;       // one ready node left to present in this round
    logic emit_final;      // the node being presented is the last one overall
  } stat_t;

endpackage

`default_nettype wire

### design/hdls_datapath.sv
// Datapath of the hazard DAG level scheduler: node table, row walk, schedule
// sets and the output register. Depends on hdls_pkg; driven by hdls_ctrl.
`default_nettype none

module hdls_datapath #(
  parameter int MAX_NODES     = 32,
  parameter int NUM_RESOURCES = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire hdls_pkg::cmd_t                      cmd,
  output hdls_pkg::stat_t                          stat,
  input  wire logic [hdls_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [hdls_pkg::OUT_DATA_W-1:0]          out_tdata,
  output logic [1:0]                               out_tuser,
  output logic                                     out_tlast
);

  localparam int RES_W   = (NUM_RESOURCES < hdls_pkg::MASK_W) ? NUM_RESOURCES
                                                               : hdls_pkg::MASK_W;
  localparam int IDX_W   = $clog2(MAX_NODES);
  localparam int CNT_W   = $clog2(MAX_NODES + 1);
  localparam int NODE_W  = hdls_pkg::NODE_W;
  localparam int LEVEL_W = hdls_pkg::LEVEL_W;

  // Input item fields.
  logic [hdls_pkg::MASK_W-1:0] in_rd, in_wr, in_deps;
  logic                        in_fin, in_run;

  // Node table.
  logic [MAX_NODES-1:0] dep_rows_r   [MAX_NODES];
  logic [RES_W-1:0]     read_rows_r  [MAX_NODES];
  logic [RES_W-1:0]     write_rows_r [MAX_NODES];
  logic [MAX_NODES-1:0] final_r, run_bits_r;
  logic [RES_W-1:0]     produced_r;
  logic [CNT_W-1:0]     count_r;

  // Item being added.
  logic [RES_W-1:0]     rd_r, wr_r;
  logic                 fin_r, run_r;
  logic [MAX_NODES-1:0] deps_r;

  // Walk and schedule sets.
  logic [IDX_W-1:0]     j_r;
  logic [MAX_NODES-1:0] remaining_r, done_r, ready_r;
  logic [LEVEL_W-1:0]   round_r;

  // Output register.
  logic                  out_valid_r, out_last_r;
  logic [NODE_W-1:0]     out_node_r;
  logic [LEVEL_W-1:0]    out_level_r;
  logic [1:0]            out_status_r;

  logic [MAX_NODES-1:0] valid_mask;
  logic [IDX_W-1:0]     idx_new;
  logic [IDX_W-1:0]     ready_low, rem_low;
  logic [MAX_NODES-1:0] ready_low_bit;
  logic                 row_hit, row_back, row_ready, out_free, out_load;

  assign in_rd   = in_tdata[31:0];
  assign in_wr   = in_tdata[63:32];
  assign in_fin  = in_tdata[64];
  assign in_deps = in_tdata[96:65];
  assign in_run  = in_tdata[97];

  assign idx_new = count_r[IDX_W-1:0];

  // Bits of node indexes that exist in the table.
  always_comb begin
    for (int i = 0; i < MAX_NODES; i++) begin
      valid_mask[i] = (CNT_W'(i) < count_r);
    end
  end

  // Lowest set bit of the ready set and of the remaining set.
  always_comb begin
    ready_low = '0;
    rem_low   = '0;
    for (int i = MAX_NODES - 1; i >= 0; i--) begin
      if (ready_r[i]) begin
        ready_low = IDX_W'(i);
      end
      if (remaining_r[i]) begin
        rem_low = IDX_W'(i);
      end
    end
  end

  assign ready_low_bit = MAX_NODES'(1) << ready_low;

  // Per-row tests at the walk index.
  assign row_hit   = (fin_r & final_r[j_r]) | (|(write_rows_r[j_r] & rd_r));
  assign row_back  = |(read_rows_r[j_r] & wr_r);
  assign row_ready = remaining_r[j_r] & ((dep_rows_r[j_r] & ~done_r) == '0);

  assign out_free = !out_valid_r || out_tready;
  assign out_load = cmd.add_commit | cmd.full_rsp | cmd.clr | cmd.emit | cmd.cyc_emit;

  // Status toward the controller.
  always_comb begin
    stat.out_free       = out_free;
    stat.count_zero     = (count_r == '0);
    stat.table_full     = (count_r == CNT_W'(MAX_NODES));
    stat.scan_done      = ((CNT_W'(j_r) + CNT_W'(1)) == count_r);
    stat.remaining_zero = (remaining_r == '0);
    stat.ready_zero     = (ready_r == '0);
    stat.ready_one      = (ready_r == ready_low_bit);
    stat.emit_final     = ((remaining_r & ~ready_low_bit) == '0);
  end

  // Control state: table occupancy, schedule sets, walk index and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      final_r     <= '0;
      run_bits_r  <= '0;
      produced_r  <= '0;
      j_r         <= '0;
      remaining_r <= '0;
      done_r      <= '0;
      ready_r     <= '0;
      round_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.capture) begin
        j_r <= '0;
      end
      if (cmd.sch_init) begin
        j_r         <= '0;
        remaining_r <= run_bits_r & valid_mask;
        done_r      <= valid_mask & ~run_bits_r;
        ready_r     <= '0;
        round_r     <= '0;
      end
      if (cmd.add_step) begin
        j_r <= stat.scan_done ? '0 : j_r + IDX_W'(1);
      end
      if (cmd.add_commit) begin
        final_r[idx_new]    <= fin_r;
        run_bits_r[idx_new] <= run_r;
        produced_r          <= produced_r | wr_r;
        count_r             <= count_r + CNT_W'(1);
      end
      if (cmd.clr) begin
        count_r    <= '0;
        final_r    <= '0;
        run_bits_r <= '0;
        produced_r <= '0;
      end
      if (cmd.eval_step) begin
        ready_r[j_r] <= row_ready;
        j_r          <= stat.scan_done ? '0 : j_r + IDX_W'(1);
      end
      // Releasing a node retires it; the round advances after its last node.
      if (cmd.emit) begin
        ready_r[ready_low]     <= 1'b0;
        remaining_r[ready_low] <= 1'b0;
        done_r[ready_low]      <= 1'b1;
        if (stat.ready_one) begin
          round_r <= round_r + LEVEL_W'(1);
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: node rows, the item being added and the output fields.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd_r   <= in_rd[RES_W-1:0];
      wr_r   <= in_wr[RES_W-1:0];
      fin_r  <= in_fin;
      run_r  <= in_run;
      deps_r <= in_deps[MAX_NODES-1:0] & valid_mask;
    end
    // Earlier hazards feed the new row; earlier readers of its writes gain it.
    if (cmd.add_step) begin
      if (row_hit) begin
        deps_r[j_r] <= 1'b1;
      end
      if (row_back) begin
        dep_rows_r[j_r][idx_new] <= 1'b1;
      end
    end
    if (cmd.add_commit) begin
      dep_rows_r[idx_new]   <= deps_r;
      read_rows_r[idx_new]  <= rd_r;
      write_rows_r[idx_new] <= wr_r;
    end
    // Result fields for each kind of result.
    if (cmd.add_commit) begin
      out_node_r   <= NODE_W'(idx_new);
      out_level_r  <= '0;
      out_status_r <= (|(wr_r & produced_r)) ? hdls_pkg::ST_DUP : hdls_pkg::ST_OK;
      out_last_r   <= 1'b1;
    end
    if (cmd.full_rsp) begin
      out_node_r   <= '0;
      out_level_r  <= '0;
      out_status_r <= hdls_pkg::ST_FULL;
      out_last_r   <= 1'b1;
    end
    if (cmd.clr) begin
      out_node_r   <= '0;
      out_level_r  <= '0;
      out_status_r <= hdls_pkg::ST_OK;
      out_last_r   <= 1'b1;
    end
    if (cmd.emit) begin
      out_node_r   <= NODE_W'(ready_low);
      out_level_r  <= round_r;
      out_status_r <= hdls_pkg::ST_OK;
      out_last_r   <= stat.ready_one & stat.emit_final;
    end
    if (cmd.cyc_emit) begin
      out_node_r   <= NODE_W'(rem_low);
      out_level_r  <= round_r;
      out_status_r <= hdls_pkg::ST_CYCLE;
      out_last_r   <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_level_r, out_node_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

### design/hdls_ctrl.sv
// Controller of the hazard DAG level scheduler: sequences add, schedule and
// clear commands. Depends on hdls_pkg; drives hdls_datapath.
`default_nettype none

module hdls_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire logic [1:0]      in_tuser,
  input  wire hdls_pkg::stat_t stat,
  output hdls_pkg::cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_SCAN,
    S_ADD_COMMIT,
    S_FULL,
    S_CLEAR,
    S_SCH_CHECK,
    S_EVAL,
    S_DECIDE,
    S_EMIT,
    S_CYCLE
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_tuser)
            hdls_pkg::MODE_ADD: begin
              cmd.capture = 1'b1;
              if (stat.table_full) begin
                state_nxt = S_FULL;
              end else if (stat.count_zero) begin
                state_nxt = S_ADD_COMMIT;
              end else begin
                state_nxt = S_ADD_SCAN;
              end
            end
            hdls_pkg::MODE_SCHED: begin
              cmd.sch_init = 1'b1;
              state_nxt    = S_SCH_CHECK;
            end
            hdls_pkg::MODE_CLEAR: begin
              state_nxt = S_CLEAR;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_ADD_SCAN: begin
        cmd.add_step = 1'b1;
        if (stat.scan_done) begin
          state_nxt = S_ADD_COMMIT;
        end
      end
      S_ADD_COMMIT: begin
        if (stat.out_free) begin
          cmd.add_commit = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_FULL: begin
        if (stat.out_free) begin
          cmd.full_rsp = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_CLEAR: begin
        if (stat.out_free) begin
          cmd.clr   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SCH_CHECK: begin
        state_nxt = stat.remaining_zero ? S_IDLE : S_EVAL;
      end
      S_EVAL: begin
        cmd.eval_step = 1'b1;
        if (stat.scan_done) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt = stat.ready_zero ? S_CYCLE : S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.ready_one) begin
            state_nxt = stat.emit_final ? S_IDLE : S_EVAL;
          end
        end
      end
      S_CYCLE: begin
        if (stat.out_free) begin
          cmd.cyc_emit = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

### design/hazard_dag_level_scheduler.sv
// Top level of the hazard DAG level scheduler: joins controller and datapath.
// Depends on hdls_pkg, hdls_ctrl and hdls_datapath.
//
// Channel  Dir  Handshake            Payload
// in_      in   in_tvalid/in_tready  tuser: mode; tdata: masks, flags, deps
// out_     out  out_tvalid/out_tready tuser: status; tdata: node, level; tlast
//
// Adding a node runs the accept step, a row walk over every stored node and a
// commit step, or a table-full step if the table is full. A schedule runs the
// accept step, a check step and, per round, a readiness test of every stored
// node, a decision step and the release of each ready node in turn, or a cycle
// step if no node is ready. Clear runs the accept step and a clear step.
// Reset is synchronous, active low, and empties the table at once.
// A stalled output holds the controller in the state that loads the next result;
// the next item is taken once the current one has placed its last result, if
// any, in the output register.
`default_nettype none

module hazard_dag_level_scheduler #(
  parameter int MAX_NODES     = 32,
  parameter int NUM_RESOURCES = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // [31:0] read_mask, [63:32] write_mask, [64] writes_final,
  // [96:65] explicit_deps, [97] run_node, [103:98] zero
  input  wire logic [hdls_pkg::IN_DATA_W-1:0]      in_tdata,
  // [1:0] mode
  input  wire logic [1:0]                          in_tuser,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // [4:0] node_index, [9:5] level, [15:10] zero
  output logic [hdls_pkg::OUT_DATA_W-1:0]          out_tdata,
  // [1:0] status
  output logic [1:0]                               out_tuser,
  output logic                                     out_tlast
);

  hdls_pkg::cmd_t  cmd;
  hdls_pkg::stat_t stat;

  hdls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .stat      (stat),
    .cmd       (cmd)
  );

  hdls_datapath #(
    .MAX_NODES     (MAX_NODES),
    .NUM_RESOURCES (NUM_RESOURCES)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

### design/hdls_checker.sv
// Port-level checks for the hazard DAG level scheduler, bound to the top level.
// Depends on hdls_pkg.
`default_nettype none

module hdls_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tvalid,
  input wire logic                           in_tready,
  input wire logic [1:0]                     in_tuser,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [hdls_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic [1:0]                     out_tuser,
  input wire logic                           out_tlast
);

  // A held result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("output result changed while stalled");

  // Error and cycle results always close their item.
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == hdls_pkg::ST_DUP || out_tuser == hdls_pkg::ST_FULL ||
      out_tuser == hdls_pkg::ST_CYCLE) |-> out_tlast)
    else $error("error or cycle result without last");

  // A table-full result names no node and no level.
  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == hdls_pkg::ST_FULL |-> out_tdata[9:0] == 10'd0)
    else $error("table-full result carries node or level");

  // An unused command is dropped and the input stays open.
  a_unused_mode: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser != hdls_pkg::MODE_ADD &&
      in_tuser != hdls_pkg::MODE_SCHED && in_tuser != hdls_pkg::MODE_CLEAR |=> in_tready)
    else $error("unused command stalled the input");

endmodule

bind hazard_dag_level_scheduler hdls_checker u_hdls_checker (.*);

`default_nettype wire

### sim/hazard_dag_level_scheduler_tb.sv
// Self-checking bench for hazard_dag_level_scheduler: node adds, level schedules and clears.
// Expected results come from a behavioral copy of the hazard table kept in this file.
// Depends on hdls_pkg and the hazard_dag_level_scheduler RTL only.
module hazard_dag_level_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Command and status codes taken from the package.
  localparam logic [1:0] MODE_ADD   = hdls_pkg::MODE_ADD;
  localparam logic [1:0] MODE_SCHED = hdls_pkg::MODE_SCHED;
  localparam logic [1:0] MODE_CLEAR = hdls_pkg::MODE_CLEAR;
  localparam logic [1:0] ST_OK      = hdls_pkg::ST_OK;
  localparam logic [1:0] ST_DUP     = hdls_pkg::ST_DUP;
  localparam logic [1:0] ST_FULL    = hdls_pkg::ST_FULL;
  localparam logic [1:0] ST_CYCLE   = hdls_pkg::ST_CYCLE;

  // Command code that the block ignores.
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int DIR_ROWS    = 22;
  localparam int RAND_ITEMS  = 300;
  localparam int QUIET_ITEMS = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_WAIT  = 100;

  // One input item plus an optional hand-typed result.
  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] rd;
    logic [31:0] wr;
    logic        fin;
    logic [31:0] deps;
    logic        run;
    logic        chk;    // result typed in below instead of computed
    logic [1:0]  n_res;  // typed result count, 0 or 1
    logic [4:0]  idx;
    logic [1:0]  st;
  } stim_row_t;

  typedef struct packed {
    logic [4:0] idx;
    logic [4:0] lvl;
    logic [1:0] st;
    logic       last;
  } sched_res_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [hdls_pkg::IN_DATA_W-1:0] in_tdata;
  logic [1:0] in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [hdls_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [1:0] out_tuser;
  logic out_tlast;

  // Shadow copy of the hazard table.
  logic [5:0]  dag_count;
  logic [31:0] dag_deps [32];
  logic [31:0] dag_reads [32];
  logic [31:0] dag_writes [32];
  logic [31:0] dag_final;
  logic [31:0] dag_run;
  logic [31:0] dag_produced;

  sched_res_t due_q[$];
  sched_res_t fresh_res[$];
  int fail_cnt;
  int rand_sent;
  int idle_cycles;
  bit quiet;
  bit hold_req;

  hazard_dag_level_scheduler u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Append a result to the list of results of the current item.
  function automatic void fresh_add(input sched_res_t x);
    fresh_res = {fresh_res, x};
  endfunction

  // Append a result to the list of results still due from the block.
  function automatic void due_add(input sched_res_t x);
    due_q = {due_q, x};
  endfunction

  // Directed items: extremes, every command, hazards, a cycle, ignored nodes.
  function automatic stim_row_t dir_row(input int k);
    stim_row_t r;
    r = '0;
    case (k)
      0:  r = '{MODE_SCHED, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0, 1'b1, 2'd0, 5'd0, ST_OK};
      1:  r = '{MODE_ADD, 32'h0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1,
                1'b1, 2'd1, 5'd0, ST_OK};
      2:  r = '{MODE_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1,
                1'b1, 2'd1, 5'd1, ST_DUP};
      3:  r = '{MODE_ADD, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0, 1'b1, 2'd1, 5'd2, ST_OK};
      4:  r = '{MODE_ADD, 32'h0000_00F0, 32'h0000_000F, 1'b0, 32'h0, 1'b1,
                1'b1, 2'd1, 5'd3, ST_DUP};
      5:  r = '{MODE_SCHED, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0, 1'b0, 2'd0, 5'd0, ST_OK};
      6:  r = '{MODE_UNUSED, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0, 1'b1, 2'd0, 5'd0, ST_OK};
      7:  r = '{MODE_CLEAR, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0, 1'b1, 2'd1, 5'd0, ST_OK};
      // Two nodes that each read what the other writes form a cycle.
      8:  r = '{MODE_ADD, 32'h1, 32'h2, 1'b0, 32'h0, 1'b1, 1'b1, 2'd1, 5'd0, ST_OK};
      9:  r = '{MODE_ADD, 32'h2, 32'h1, 1'b0, 32'h0, 1'b1, 1'b1, 2'd1, 5'd1, ST_OK};
      10: r = '{MODE_SCHED, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0, 1'b1, 2'd1, 5'd0, ST_CYCLE};
      11: r = '{MODE_CLEAR, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0, 1'b1, 2'd1, 5'd0, ST_OK};
      // A chain with final-image writers, an ignored node and explicit deps.
      12: r = '{MODE_ADD, 32'h0, 32'h1, 1'b0, 32'h0, 1'b1, 1'b1, 2'd1, 5'd0, ST_OK};
      13: r = '{MODE_ADD, 32'h1, 32'h2, 1'b1, 32'h0, 1'b1, 1'b1, 2'd1, 5'd1, ST_OK};
      14: r = '{MODE_ADD, 32'h2, 32'h4, 1'b1, 32'h0, 1'b0, 1'b1, 2'd1, 5'd2, ST_OK};
      15: r = '{MODE_ADD, 32'h4, 32'h8, 1'b0, 32'h1, 1'b1, 1'b1, 2'd1, 5'd3, ST_OK};
      16: r = '{MODE_ADD, 32'h0, 32'h0, 1'b0, 32'hFFFF_FFFF, 1'b1,
                1'b1, 2'd1, 5'd4, ST_OK};
      17: r = '{MODE_SCHED, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0, 1'b0, 2'd0, 5'd0, ST_OK};
      // A late writer of a resource read earlier pushes the reader back.
      18: r = '{MODE_ADD, 32'h0, 32'h1, 1'b0, 32'h0, 1'b1, 1'b1, 2'd1, 5'd5, ST_DUP};
      19: r = '{MODE_SCHED, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0, 1'b0, 2'd0, 5'd0, ST_OK};
      20: r = '{MODE_CLEAR, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0, 1'b1, 2'd1, 5'd0, ST_OK};
      default: r = '{MODE_SCHED, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0, 1'b1, 2'd0, 5'd0, ST_OK};
    endcase
    return r;
  endfunction

  // Apply one item to the shadow table and collect the results it causes.
  task automatic dag_apply(input stim_row_t r);
    logic [31:0] d;
    logic [31:0] valid;
    logic [31:0] remaining;
    logic [31:0] done;
    logic [31:0] ready;
    int j;
    int low;
    int round;
    sched_res_t e;
    fresh_res.delete();
    case (r.mode)
      MODE_ADD: begin
        if (dag_count >= 6'd32) begin
          fresh_add('{5'd0, 5'd0, ST_FULL, 1'b1});
        end else begin
          e = '{dag_count[4:0], 5'd0, (|(r.wr & dag_produced)) ? ST_DUP : ST_OK, 1'b1};
          dag_produced = dag_produced | r.wr;
          d = r.deps & ((32'd1 << dag_count) - 32'd1);
          for (j = 0; j < dag_count; j++) begin
            if (r.fin && dag_final[j]) d[j] = 1'b1;
            if (|(dag_writes[j] & r.rd)) d[j] = 1'b1;
            if (|(r.wr & dag_reads[j])) dag_deps[j][dag_count] = 1'b1;
          end
          dag_deps[dag_count] = d;
          dag_reads[dag_count] = r.rd;
          dag_writes[dag_count] = r.wr;
          dag_final[dag_count] = r.fin;
          dag_run[dag_count] = r.run;
          dag_count = dag_count + 6'd1;
          fresh_add(e);
        end
      end
      MODE_SCHED: begin
        valid = (dag_count == 6'd32) ? 32'hFFFF_FFFF : ((32'd1 << dag_count) - 32'd1);
        remaining = dag_run & valid;
        done = valid & ~dag_run;
        round = 0;
        // Release one level per round; ignored nodes start out done.
        while (remaining != 32'd0) begin
          ready = 32'd0;
          for (j = 0; j < dag_count; j++) begin
            if (remaining[j] && (dag_deps[j] & ~done) == 32'd0) ready[j] = 1'b1;
          end
          if (ready == 32'd0) begin
            low = 0;
            while (!remaining[low]) low++;
            fresh_add('{5'(low), 5'(round), ST_CYCLE, 1'b1});
            return;
          end
          for (j = 0; j < 32; j++) begin
            if (ready[j]) fresh_add('{5'(j), 5'(round), ST_OK, 1'b0});
          end
          remaining = remaining & ~ready;
          done = done | ready;
          round++;
        end
        if (fresh_res.size() > 0) begin
          e = fresh_res.pop_back();
          e.last = 1'b1;
          fresh_add(e);
        end
      end
      MODE_CLEAR: begin
        dag_count = 6'd0;
        dag_final = 32'd0;
        dag_run = 32'd0;
        dag_produced = 32'd0;
        fresh_add('{5'd0, 5'd0, ST_OK, 1'b1});
      end
      default: ;
    endcase
  endtask

  // Offer one item, wait for the handshake, then record what it should produce.
  task automatic send_item(input stim_row_t r);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= r.mode;
    in_tdata <= {6'd0, r.run, r.deps, r.fin, r.wr, r.rd};
    do @(posedge clk); while (!in_tready);
    dag_apply(r);
    if (r.chk) begin
      if (r.n_res != 2'd0) due_add('{r.idx, 5'd0, r.st, 1'b1});
    end else begin
      foreach (fresh_res[i]) due_add(fresh_res[i]);
    end
  endtask

  // Random item with the given command and random payload.
  function automatic stim_row_t rand_cmd(input logic [1:0] mode);
    stim_row_t r;
    r = '0;
    r.mode = mode;
    r.rd = $urandom;
    r.wr = $urandom;
    r.fin = $urandom_range(0, 1);
    r.deps = $urandom;
    r.run = $urandom_range(0, 1);
    return r;
  endfunction

  // Stimulus: reset, directed table, then sequences of random graphs.
  initial begin
    stim_row_t r;
    int k;
    int seq_no;
    int n_nodes;
    int res_base;
    int n_sched;
    bit tidy;
    logic [31:0] written;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = MODE_ADD;
    dag_count = 6'd0;
    dag_final = 32'd0;
    dag_run = 32'd0;
    dag_produced = 32'd0;
    fail_cnt = 0;
    rand_sent = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < DIR_ROWS; k++) send_item(dir_row(k));

    // The first sequence fills past the table size while the receiver holds off.
    hold_req = 1'b1;
    seq_no = 0;
    while (rand_sent < RAND_ITEMS) begin
      if (seq_no == 0 || $urandom_range(0, 4) != 0) begin
        send_item(rand_cmd(MODE_CLEAR));
        rand_sent++;
      end
      if (seq_no == 0) n_nodes = 34;
      else if ($urandom_range(0, 11) == 0) n_nodes = $urandom_range(30, 34);
      else n_nodes = $urandom_range(1, 9);
      tidy = ($urandom_range(0, 9) < 7);
      res_base = $urandom_range(0, 31);
      written = 32'd0;
      for (k = 0; k < n_nodes; k++) begin
        // Occasional noise: an ignored command or an early schedule.
        if ($urandom_range(0, 19) == 0) begin
          send_item(rand_cmd(MODE_UNUSED));
        end else if ($urandom_range(0, 19) == 0) begin
          send_item(rand_cmd(MODE_SCHED));
          rand_sent++;
        end
        r = rand_cmd(MODE_ADD);
        if (tidy) begin
          // Each node writes a fresh resource and reads some earlier outputs.
          r.wr = 32'd1 << ((res_base + k) % 32);
          r.rd = written & $urandom & $urandom;
          written = written | r.wr;
        end else if ($urandom_range(0, 4) != 0) begin
          r.rd = $urandom & $urandom;
          r.wr = $urandom & $urandom & $urandom;
        end
        r.fin = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 3) != 0) r.deps = $urandom & $urandom & $urandom;
        r.run = ($urandom_range(0, 7) != 0);
        send_item(r);
        rand_sent++;
        quiet = (rand_sent >= RAND_ITEMS - QUIET_ITEMS);
      end
      // Once, withdraw the input and let every result drain before the schedule.
      if (seq_no == 2) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        wait (due_q.size() == 0);
      end
      n_sched = $urandom_range(1, 2);
      repeat (n_sched) begin
        send_item(rand_cmd(MODE_SCHED));
        rand_sent++;
      end
      quiet = (rand_sent >= RAND_ITEMS - QUIET_ITEMS);
      seq_no++;
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    wait (due_q.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Result side: random short stalls, one long hold-off, none near the end.
  initial begin
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        stall_left = $urandom_range(0, 2);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic chk_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  // Compare each accepted result with the oldest one still due.
  always @(posedge clk) begin : res_check
    sched_res_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_q.size() == 0) begin
        $error("result with none due: node_index %0d, level %0d, status %0d",
               out_tdata[4:0], out_tdata[9:5], out_tuser);
        fail_cnt++;
      end else begin
        e = due_q.pop_front();
        chk_field("node_index", e.idx, out_tdata[4:0]);
        chk_field("level", e.lvl, out_tdata[9:5]);
        chk_field("status", e.st, out_tuser);
        chk_field("last", e.last, out_tlast);
      end
    end
  end

  // Watchdog: too long without any item moving on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

endmodule
